>>> rtl/core/page_range_membership_table_macros.svh
// Assertion macros for the checker file of the page range table.
`ifndef PAGE_RANGE_MEMBERSHIP_TABLE_MACROS_SVH
`define PAGE_RANGE_MEMBERSHIP_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define PRMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define PRMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/prmt_pkg.sv
`default_nettype none

package prmt_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int PAGE_SHIFT   = 12;
  localparam int ADDRESS_BITS = 48;
  localparam int PAGE_BITS    = ADDRESS_BITS - PAGE_SHIFT;
  localparam int COUNT_BITS   = $clog2(TABLE_DEPTH + 1);

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [ADDRESS_BITS-1:0] first_address;
    logic [ADDRESS_BITS-1:0] end_address;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic                  refused;
    logic [COUNT_BITS-1:0] used_entries;
  } out_item_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] low_page;
    logic [PAGE_BITS-1:0] high_page;
  } entry_t;

  // A lookup travelling down the row of cells.
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [PAGE_BITS-1:0] page;
  } token_t;

  function automatic logic [PAGE_BITS-1:0] page_of(input logic [ADDRESS_BITS-1:0] address);
    page_of = address[ADDRESS_BITS-1:PAGE_SHIFT];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/prmt_cell.sv
`default_nettype none

module prmt_cell
  import prmt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   shift_en,
  input  wire entry_t entry_in,
  output entry_t      entry_out,
  input  wire logic   active,
  input  wire token_t tok_in,
  output token_t      tok_out
);

  entry_t entry_r;
  logic   tok_valid_r;
  logic   tok_hit_r;
  logic [PAGE_BITS-1:0] tok_page_r;
  logic   match;

  // An add pushes every entry one cell further down, so the newest is in cell 0.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= entry_in;
    end
  end

  assign match = active && (entry_r.low_page <= tok_in.page) &&
                 (tok_in.page < entry_r.high_page);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_hit_r  <= tok_in.hit | match;
    tok_page_r <= tok_in.page;
  end

  assign entry_out     = entry_r;
  assign tok_out.valid = tok_valid_r;
  assign tok_out.hit   = tok_hit_r;
  assign tok_out.page  = tok_page_r;

endmodule

`default_nettype wire

>>> rtl/core/page_range_membership_table.sv
`default_nettype none

// Page range membership table.
// An item is accepted on a rising edge with start high and busy low. An add
// item (kind 0) stores the pages of first_address and end_address as a new
// range; a lookup item (kind 1) asks whether the page of first_address lies
// in any stored range. Each item gives one result on out_item, shown for one
// cycle with out_strobe high; the receiver cannot stall the block.
// An add gives its result in the cycle after acceptance and the next item can
// be taken in that same cycle, so adds run at one per cycle. A lookup walks
// down the row of TABLE_DEPTH cells, one cell per cycle; its result is
// registered when the token leaves the last cell. Busy is high until the
// result shows, so the block takes no new item while a lookup walks the cells.
// When all entries are used an add is refused and flagged, and the table
// is left unchanged.
// A synchronous reset empties the table; no clearing pass is needed.

module page_range_membership_table
  import prmt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_strobe,
  output out_item_t     out_item
);

  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  busy_r;
  logic                  out_strobe_r;
  out_item_t             out_item_r;
  logic                  accept;
  logic                  add_accept;
  logic                  lookup_accept;
  logic                  full;
  logic                  shift_en;
  logic [TABLE_DEPTH-1:0] active;
  entry_t                entry_link [TABLE_DEPTH+1];
  token_t                tok_link   [TABLE_DEPTH+1];

  assign accept        = start && !busy_r;
  assign add_accept    = accept && (in_item.kind == KIND_ADD);
  assign lookup_accept = accept && (in_item.kind == KIND_LOOKUP);
  assign full          = (count_r == COUNT_BITS'(TABLE_DEPTH));
  assign shift_en      = add_accept && !full;
  assign count_nxt     = full ? count_r : count_r + COUNT_BITS'(1);

  assign entry_link[0].low_page  = page_of(in_item.first_address);
  assign entry_link[0].high_page = page_of(in_item.end_address);
  assign tok_link[0].valid       = lookup_accept;
  assign tok_link[0].hit         = 1'b0;
  assign tok_link[0].page        = page_of(in_item.first_address);

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    // Only the first count_r cells hold entries written since reset.
    assign active[k] = (COUNT_BITS'(k) < count_r);

    prmt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .entry_in (entry_link[k]),
      .entry_out(entry_link[k+1]),
      .active   (active[k]),
      .tok_in   (tok_link[k]),
      .tok_out  (tok_link[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (add_accept) begin
        count_r      <= count_nxt;
        out_strobe_r <= 1'b1;
      end
      if (lookup_accept) begin
        busy_r <= 1'b1;
      end
      if (tok_link[TABLE_DEPTH].valid) begin
        busy_r       <= 1'b0;
        out_strobe_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_accept) begin
      out_item_r.hit          <= 1'b0;
      out_item_r.refused      <= full;
      out_item_r.used_entries <= count_nxt;
    end else if (tok_link[TABLE_DEPTH].valid) begin
      out_item_r.hit          <= tok_link[TABLE_DEPTH].hit;
      out_item_r.refused      <= 1'b0;
      out_item_r.used_entries <= count_r;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

>>> rtl/core/prmt_checker.sv
`default_nettype none

`include "page_range_membership_table_macros.svh"

module prmt_checker
  import prmt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      out_strobe,
  input wire out_item_t out_item
);

  // An add answers in the very next cycle and never reports a hit.
  `PRMT_ASSERT_NEXT(a_add_result, start && !busy && in_item.kind == KIND_ADD, out_strobe && !out_item.hit, "add item gave no result in the next cycle")

  // A lookup holds the input channel off while it walks the cells.
  `PRMT_ASSERT_NEXT(a_lookup_busy, start && !busy && in_item.kind == KIND_LOOKUP, busy && !out_strobe, "lookup item did not hold busy")

  // A refusal only happens on a full table.
  `PRMT_ASSERT_NOW(a_refused_full, out_strobe && out_item.refused, out_item.used_entries == COUNT_BITS'(TABLE_DEPTH) && !out_item.hit, "refused add on a table that is not full")

  // The entry count never passes the table depth.
  `PRMT_ASSERT_NOW(a_count_bound, out_strobe, out_item.used_entries <= COUNT_BITS'(TABLE_DEPTH), "entry count beyond table depth")

endmodule

bind page_range_membership_table prmt_checker u_prmt_checker (.*);

`default_nettype wire
